>>> hw/rtl/serial_packet_checker_macros.svh
// Assertion macros used by the packet checker RTL.
`ifndef SERIAL_PACKET_CHECKER_MACROS_SVH
`define SERIAL_PACKET_CHECKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on clk, off while arst_n is low.
`define SPC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while arst_n is low.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SPC_ASSERT_IMPL(label, ante, cons, msg)
`define SPC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> hw/rtl/spc_pkg.sv
// Shared types and constants of the serial packet checker.
package spc_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_POS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_POS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WORD_POS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WORD_POS = 3'd5;

	localparam logic [5:0] RST_PACKET_LENGTH   = 6'd14;
	localparam logic [4:0] RST_CHECKSUM_POS    = 5'd12;
	localparam logic [7:0] RST_END_MARKER      = 8'd0;
	localparam logic [4:0] RST_CODE_POS        = 5'd0;
	localparam logic [4:0] RST_FIRST_WORD_POS  = 5'd1;
	localparam logic [4:0] RST_SECOND_WORD_POS = 5'd5;

	// captured byte slots: code, first word bytes, second word bytes, checksum
	localparam int unsigned SLOT_CODE  = 0;
	localparam int unsigned SLOT_FIRST = 1;
	localparam int unsigned SLOT_SECND = 5;
	localparam int unsigned SLOT_CSUM  = 9;
	localparam int unsigned NUM_SLOTS  = 10;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_END_ERR  = 2'd1,
		STATUS_LEN_ERR  = 2'd2,
		STATUS_CSUM_ERR = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  code_byte;
		logic [31:0] first_word;
		logic [31:0] second_word;
	} result_t;

endpackage

>>> hw/rtl/spc_ifs.sv
// Stream and configuration interfaces of the serial packet checker.
interface spc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       chunk_end;
	modport source(output valid, rx_byte, chunk_end, input ready);
	modport sink(input valid, rx_byte, chunk_end, output ready);
endinterface

interface spc_out_if;
	logic             valid;
	logic             ready;
	spc_pkg::status_t status;
	logic [7:0]       code_byte;
	logic [31:0]      first_word;
	logic [31:0]      second_word;
	modport source(output valid, status, code_byte, first_word, second_word, input ready);
	modport sink(input valid, status, code_byte, first_word, second_word, output ready);
endinterface

interface spc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [spc_pkg::CFG_IDX_W-1:0]  index;
	logic [spc_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/serial_packet_checker.sv
// Serial packet checker top level: byte-sum checksum packet deframer.
//
// Takes one received byte per word on rx, one word per clock while rx is ready.
// A word flagged chunk_end closes the packet and yields one registered result
// word on res: end marker, then length, then checksum is checked, and on
// success the code byte and two little-endian 32-bit words are reported. The
// needed bytes are captured in slot registers as they arrive, so the check is
// combinational compare logic. A two-deep result register (output plus skid)
// keeps rx ready while one result waits; rx stalls only when both are full.
// Bytes beyond MAX_BYTES are dropped and, with a good end marker, give a length
// error. Registers on cfg must only change while the block is idle.
`include "serial_packet_checker_macros.svh"

module serial_packet_checker #(
	parameter int unsigned MAX_BYTES = 32
) (
	input logic       clk,
	input logic       arst_n,
	spc_in_if.sink    rx,
	spc_out_if.source res,
	spc_cfg_if.sink   cfg
);

	localparam int unsigned CNT_W = $clog2(MAX_BYTES + 1);
	localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;

	logic [5:0] len_q;
	logic [4:0] csp_q;
	logic [7:0] end_q;
	logic [4:0] code_pos_q;
	logic [4:0] fw_pos_q;
	logic [4:0] sw_pos_q;

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic             ovf_q;
	logic [7:0]       slot_q [spc_pkg::NUM_SLOTS];

	spc_pkg::result_t out_q, skid_q, res_nx;
	logic             out_v_q, skid_v_q;

	logic             rx_acc, push, pop, room;
	logic [CNT_W-1:0] cnt_nx;
	logic [CMP_W-1:0] cnt_x, cnt_nx_x;
	logic [7:0]       sum_nx;
	logic             ovf_nx;
	logic [5:0]       pos [spc_pkg::NUM_SLOTS];
	logic             hit_old [spc_pkg::NUM_SLOTS];
	logic             hit_new [spc_pkg::NUM_SLOTS];
	logic [7:0]       val [spc_pkg::NUM_SLOTS];
	spc_pkg::status_t status_nx;

	assign cfg.ready = 1'b1;
	assign rx.ready  = !skid_v_q;
	assign rx_acc    = rx.valid && rx.ready;
	assign push      = rx_acc && rx.chunk_end;
	assign pop       = out_v_q && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= spc_pkg::RST_PACKET_LENGTH;
			csp_q      <= spc_pkg::RST_CHECKSUM_POS;
			end_q      <= spc_pkg::RST_END_MARKER;
			code_pos_q <= spc_pkg::RST_CODE_POS;
			fw_pos_q   <= spc_pkg::RST_FIRST_WORD_POS;
			sw_pos_q   <= spc_pkg::RST_SECOND_WORD_POS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spc_pkg::CFG_PACKET_LENGTH:   len_q      <= cfg.data[5:0];
				spc_pkg::CFG_CHECKSUM_POS:    csp_q      <= cfg.data[4:0];
				spc_pkg::CFG_END_MARKER:      end_q      <= cfg.data;
				spc_pkg::CFG_CODE_POS:        code_pos_q <= cfg.data[4:0];
				spc_pkg::CFG_FIRST_WORD_POS:  fw_pos_q   <= cfg.data[4:0];
				spc_pkg::CFG_SECOND_WORD_POS: sw_pos_q   <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		room     = cnt_q < CNT_W'(MAX_BYTES);
		cnt_nx   = cnt_q + CNT_W'(room);
		cnt_x    = CMP_W'(cnt_q);
		cnt_nx_x = CMP_W'(cnt_nx);
		ovf_nx   = ovf_q || !room;
		sum_nx   = sum_q + ((room && (cnt_x < CMP_W'(csp_q))) ? rx.rx_byte : 8'd0);

		pos[spc_pkg::SLOT_CODE] = {1'b0, code_pos_q};
		pos[spc_pkg::SLOT_CSUM] = {1'b0, csp_q};
		for (int k = 0; k < 4; k++) begin
			pos[spc_pkg::SLOT_FIRST + k] = {1'b0, fw_pos_q} + 6'(k);
			pos[spc_pkg::SLOT_SECND + k] = {1'b0, sw_pos_q} + 6'(k);
		end

		// a byte is in the packet if stored earlier, or if it is this word
		for (int j = 0; j < spc_pkg::NUM_SLOTS; j++) begin
			hit_old[j] = CMP_W'(pos[j]) < cnt_x;
			hit_new[j] = (CMP_W'(pos[j]) == cnt_x) && room;
			val[j]     = hit_old[j] ? slot_q[j] : (hit_new[j] ? rx.rx_byte : 8'd0);
		end

		if (rx.rx_byte != end_q) begin
			status_nx = spc_pkg::STATUS_END_ERR;
		end else if (ovf_nx || (cnt_nx_x != CMP_W'(len_q))) begin
			status_nx = spc_pkg::STATUS_LEN_ERR;
		end else if ((CMP_W'(csp_q) >= cnt_nx_x) || (val[spc_pkg::SLOT_CSUM] != sum_nx)) begin
			status_nx = spc_pkg::STATUS_CSUM_ERR;
		end else begin
			status_nx = spc_pkg::STATUS_OK;
		end

		res_nx = '0;
		res_nx.status = status_nx;
		if (status_nx == spc_pkg::STATUS_OK) begin
			res_nx.code_byte   = val[spc_pkg::SLOT_CODE];
			res_nx.first_word  = {val[spc_pkg::SLOT_FIRST + 3], val[spc_pkg::SLOT_FIRST + 2],
				val[spc_pkg::SLOT_FIRST + 1], val[spc_pkg::SLOT_FIRST]};
			res_nx.second_word = {val[spc_pkg::SLOT_SECND + 3], val[spc_pkg::SLOT_SECND + 2],
				val[spc_pkg::SLOT_SECND + 1], val[spc_pkg::SLOT_SECND]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (rx_acc) begin
			if (rx.chunk_end) begin
				cnt_q <= '0;
				sum_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= cnt_nx;
				sum_q <= sum_nx;
				ovf_q <= ovf_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < spc_pkg::NUM_SLOTS; j++) begin
			if (rx_acc && hit_new[j]) begin
				slot_q[j] <= rx.rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_q <= res_nx;
			end else begin
				out_q <= res_nx;
			end
		end
	end

	assign res.valid       = out_v_q;
	assign res.status      = out_q.status;
	assign res.code_byte   = out_q.code_byte;
	assign res.first_word  = out_q.first_word;
	assign res.second_word = out_q.second_word;

	`SPC_ASSERT_IMPL(a_skid_needs_out, skid_v_q, out_v_q, "skid word held with output empty")
	`SPC_ASSERT_IMPL(a_err_zero_fields, out_v_q && (out_q.status != spc_pkg::STATUS_OK), (out_q.code_byte == 8'd0) && (out_q.first_word == 32'd0) && (out_q.second_word == 32'd0), "error result carries field data")
	`SPC_ASSERT_NEXT(a_count_cleared, push, (cnt_q == '0) && (sum_q == 8'd0) && !ovf_q, "packet state not cleared after chunk end")
	`SPC_ASSERT_IMPL(a_count_bound, 1'b1, cnt_q <= CNT_W'(MAX_BYTES), "byte count beyond capacity")
	`SPC_ASSERT_NEXT(a_push_shows, push, out_v_q, "result word lost after chunk end")

endmodule
